@@ rtl/atsk_pkg.sv @@
`default_nettype none
package atsk_pkg;

  typedef enum logic [2:0] {
    K_WCHAR = 3'd0,
    K_WEND  = 3'd1,
    K_SCHAR = 3'd2,
    K_SEND  = 3'd3,
    K_NUM   = 3'd4,
    K_PUNCT = 3'd5,
    K_EOL   = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  code;
    logic [31:0] value;
    logic        err;
    logic        last;
  } result_t;

  typedef struct packed {
    result_t first;
    logic    two;
    result_t second;
  } entry_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage
`default_nettype wire

@@ rtl/assembler_source_tokenizer.sv @@
`default_nettype none
// Channel | Handshake            | Payload
// input   | in_valid, in_ready   | char_byte
// output  | out_valid, out_ready | token_kind, char_code, number_value, error_flag, last_of_run
//
// One byte is taken per cycle while the entry queue has room; the lexer state
// updates in that cycle. A byte that closes one token and opens another may yield
// two results, which the output stage sends one after the other. Results leave
// from a registered output stage that loads from the head of the queue.
// Reset clears the lexer state, the queue and the output stage.
// A stalled output fills the queue, then drops in_ready.
module assembler_source_tokenizer #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       token_kind,
  output logic [7:0]       char_code,
  output logic [31:0]      number_value,
  output logic             error_flag,
  output logic             last_of_run
);
  import atsk_pkg::*;

  entry_t  push_entry, head;
  logic    push, full, pop, head_valid;
  result_t result;

  assign in_ready = !full;

  atsk_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_byte (char_byte),
    .accept    (in_valid && in_ready),
    .entry     (push_entry),
    .push      (push)
  );

  atsk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  atsk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign token_kind   = result.kind;
  assign char_code    = result.code;
  assign number_value = result.value;
  assign error_flag   = result.err;
  assign last_of_run  = result.last;

endmodule
`default_nettype wire

@@ rtl/atsk_front.sv @@
`default_nettype none
module atsk_front #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      char_byte,
  input  wire logic            accept,
  output atsk_pkg::entry_t     entry,
  output logic                 push
);
  import atsk_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_WORD   = 4'd1,
    M_DEC    = 4'd2,
    M_HEXPRE = 4'd3,
    M_HEX    = 4'd4,
    M_BINPRE = 4'd5,
    M_BIN    = 4'd6,
    M_STR    = 4'd7,
    M_STRQ   = 4'd8
  } mode_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5a;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7a;
  localparam logic [7:0] CH_US     = 8'h5f;
  localparam logic [7:0] HEX_UOFS  = 8'h37;
  localparam logic [7:0] HEX_LOFS  = 8'h57;

  mode_t                   mode, mode_next;
  logic [NUMBER_WIDTH-1:0] acc, acc_next;
  logic                    quote, quote_next;

  logic                    is_alpha, is_digit, is_word, is_space, is_eol, is_bin;
  logic [7:0]              qchar, hv8;
  logic [NUMBER_WIDTH-1:0] dig_ext, hex_ext, acc_dec, acc_hex, acc_bin;
  logic [NUMBER_WIDTH+31:0] acc_wide;
  logic [31:0]             acc_low;

  mode_t                   st_mode;
  logic                    st_emit, st_load, st_quote;
  logic [NUMBER_WIDTH-1:0] st_acc;
  result_t                 st_res, pre_res;
  logic                    pre_emit, restart;

  always_comb begin
    is_alpha = (char_byte >= CH_LA && char_byte <= CH_LZ) ||
               (char_byte >= CH_UA && char_byte <= CH_UZ);
    is_digit = char_byte >= CH_ZERO && char_byte <= CH_NINE;
    is_word  = is_alpha || is_digit || char_byte == CH_US;
    is_space = (char_byte >= CH_TAB && char_byte <= CH_CR) || char_byte == CH_SPACE;
    is_eol   = char_byte == 8'd0 || char_byte[7];
    is_bin   = char_byte == CH_ZERO || char_byte == CH_ONE;
    qchar    = quote ? CH_SQUOTE : CH_DQUOTE;
    if (is_digit) begin
      hv8 = char_byte - CH_ZERO;
    end else if (char_byte >= CH_LA) begin
      hv8 = char_byte - HEX_LOFS;
    end else begin
      hv8 = char_byte - HEX_UOFS;
    end
    dig_ext  = {{(NUMBER_WIDTH-4){1'b0}}, char_byte[3:0]};
    hex_ext  = {{(NUMBER_WIDTH-6){1'b0}}, hv8[5:0]};
    acc_dec  = (acc << 3) + (acc << 1) + dig_ext;
    acc_hex  = (acc << 4) + hex_ext;
    acc_bin  = (acc << 1) + {{(NUMBER_WIDTH-1){1'b0}}, char_byte[0]};
    acc_wide = {32'd0, acc};
    acc_low  = acc_wide[31:0];
  end

  always_comb begin
    st_mode  = M_IDLE;
    st_emit  = 1'b0;
    st_load  = 1'b0;
    st_acc   = '0;
    st_quote = quote;
    st_res   = '0;
    if (is_eol) begin
      st_emit     = 1'b1;
      st_res.kind = K_EOL;
    end else if (is_space) begin
      st_mode = M_IDLE;
    end else if (is_alpha || char_byte == CH_US) begin
      st_mode     = M_WORD;
      st_emit     = 1'b1;
      st_res.kind = K_WCHAR;
      st_res.code = char_byte;
    end else if (is_digit) begin
      st_mode = M_DEC;
      st_load = 1'b1;
      st_acc  = dig_ext;
    end else if (char_byte == CH_DOLLAR) begin
      st_mode = M_HEXPRE;
      st_load = 1'b1;
    end else if (char_byte == CH_PCT) begin
      st_mode = M_BINPRE;
      st_load = 1'b1;
    end else if (char_byte == CH_DQUOTE || char_byte == CH_SQUOTE) begin
      st_mode  = M_STR;
      st_quote = char_byte == CH_SQUOTE;
    end else begin
      st_emit     = 1'b1;
      st_res.kind = K_PUNCT;
      st_res.code = char_byte;
    end
  end

  always_comb begin
    pre_emit   = 1'b0;
    pre_res    = '0;
    restart    = 1'b0;
    mode_next  = mode;
    acc_next   = acc;
    quote_next = quote;
    unique case (mode)
      M_WORD: begin
        pre_emit = 1'b1;
        if (is_word) begin
          pre_res.kind = K_WCHAR;
          pre_res.code = char_byte;
        end else begin
          pre_res.kind = K_WEND;
          restart      = 1'b1;
        end
      end
      M_DEC: begin
        if (is_digit) begin
          acc_next = acc_dec;
        end else begin
          pre_emit      = 1'b1;
          pre_res.kind  = K_NUM;
          pre_res.value = acc_low;
          restart       = 1'b1;
        end
      end
      M_HEXPRE, M_HEX: begin
        if (is_alpha || is_digit) begin
          acc_next  = acc_hex;
          mode_next = M_HEX;
        end else begin
          pre_emit      = 1'b1;
          pre_res.kind  = K_NUM;
          pre_res.value = acc_low;
          pre_res.err   = mode == M_HEXPRE;
          restart       = 1'b1;
        end
      end
      M_BINPRE, M_BIN: begin
        if (is_bin) begin
          acc_next  = acc_bin;
          mode_next = M_BIN;
        end else begin
          pre_emit      = 1'b1;
          pre_res.kind  = K_NUM;
          pre_res.value = acc_low;
          pre_res.err   = mode == M_BINPRE;
          restart       = 1'b1;
        end
      end
      M_STR: begin
        if (is_eol) begin
          pre_emit     = 1'b1;
          pre_res.kind = K_SEND;
          pre_res.err  = 1'b1;
          restart      = 1'b1;
        end else if (char_byte == qchar) begin
          mode_next = M_STRQ;
        end else begin
          pre_emit     = 1'b1;
          pre_res.kind = K_SCHAR;
          pre_res.code = char_byte;
        end
      end
      M_STRQ: begin
        pre_emit = 1'b1;
        if (char_byte == qchar) begin
          pre_res.kind = K_SCHAR;
          pre_res.code = char_byte;
          mode_next    = M_STR;
        end else begin
          pre_res.kind = K_SEND;
          restart      = 1'b1;
        end
      end
      M_IDLE: restart = 1'b1;
      default: restart = 1'b1;
    endcase
    if (restart) begin
      mode_next  = st_mode;
      quote_next = st_quote;
      if (st_load) begin
        acc_next = st_acc;
      end
    end
  end

  always_comb begin
    entry = '0;
    if (pre_emit) begin
      entry.first  = pre_res;
      entry.two    = restart && st_emit;
      entry.second = st_res;
    end else begin
      entry.first = st_res;
    end
    entry.first.last  = !entry.two;
    entry.second.last = 1'b1;
    push = accept && (pre_emit || (restart && st_emit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      acc   <= '0;
      quote <= 1'b0;
    end else if (accept) begin
      mode  <= mode_next;
      acc   <= acc_next;
      quote <= quote_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    push && entry.two |-> restart && pre_emit)
    else $error("second result without a closed token");
  assert property (@(posedge clk) disable iff (rst)
    accept && mode == M_STRQ && char_byte != qchar |=> mode != M_STRQ)
    else $error("closed string did not leave string mode");

endmodule
`default_nettype wire

@@ rtl/atsk_queue.sv @@
`default_nettype none
module atsk_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire atsk_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output atsk_pkg::entry_t       head,
  output logic                   head_valid
);
  import atsk_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W:0]     count;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ rtl/atsk_back.sv @@
`default_nettype none
module atsk_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire atsk_pkg::entry_t  head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output atsk_pkg::result_t      result
);
  import atsk_pkg::*;

  logic phase;
  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = load && head_valid && (phase || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        result <= phase ? head.second : head.first;
        phase  <= !phase && head.two;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !result.last |=> out_valid)
    else $error("second result of a byte missing");
  assert property (@(posedge clk) disable iff (rst)
    phase |-> head_valid)
    else $error("split entry left the queue early");

endmodule
`default_nettype wire
